// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the scheduler datapath; empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- design/csch_pkg.sv -----
// ----------------------------------------------------------------------------
// csch_pkg
// Types, codes and constants of the credit device scheduler
// ----------------------------------------------------------------------------
package csch_pkg;

  // geometry
  localparam int DEVICES     = 4;
  localparam int DEV_W       = $clog2(DEVICES);
  localparam int MAX_WAITING = 255;
  localparam int WAIT_W      = $clog2(MAX_WAITING + 1);

  // field widths
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int AMOUNT_W   = 24;
  localparam int CREDIT_W   = 32;
  localparam int PERIOD_W   = 20;
  localparam int THRESH_W   = 27;
  localparam int SHARE_W    = 7;

  // stream and register port widths
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 40;
  localparam int APB_W      = 32;
  localparam int ADDR_W     = 5;

  // replenish: period * share / 100, done as (x >> 2) / 25 by reciprocal
  localparam int PERCENT     = 100;
  localparam int PCT_SHIFT   = 2;
  localparam int PCT_ODD     = PERCENT / 4;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = 23;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / PCT_ODD;
  localparam int PROD_W      = PERIOD_W + SHARE_W;
  localparam int Y_W         = PROD_W - PCT_SHIFT;
  localparam int LO_W        = 13;
  localparam int HI_W        = Y_W - LO_W;
  localparam int SUM_W       = Y_W + RECIP_W;
  localparam int QUOT_W      = SUM_W - RECIP_SHIFT;

  typedef logic [DEVICES-1:0][SHARE_W-1:0] share_arr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST   = 2'd0,
    KIND_RELEASE   = 2'd1,
    KIND_REPLENISH = 2'd2,
    KIND_CHARGE    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED = 3'd0,
    STAT_QUEUED  = 3'd1,
    STAT_NEXT    = 3'd2,
    STAT_IDLE    = 3'd3,
    STAT_UPDATED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_PERIOD    = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_SHARE0    = 3'd2,
    REG_SHARE1    = 3'd3,
    REG_SHARE2    = 3'd4,
    REG_SHARE3    = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_RECIP_LO,
    ST_RECIP_HI,
    ST_QUOT,
    ST_FIX,
    ST_ADD,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_request;
    logic do_move;
    logic do_scan;
    logic do_charge;
    logic do_mul;
    logic recip_lo;
    logic recip_hi;
    logic quot;
    logic fix;
    logic do_replenish;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scan_hit;
    logic  scan_last;
    logic  out_free;
  } ctrl_stat_t;

endpackage

// ----- design/csch_regs.sv -----
// ----------------------------------------------------------------------------
// csch_regs
// Register file of the scheduler on its APB-style port
// ----------------------------------------------------------------------------
module csch_regs import csch_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready,
  output logic [PERIOD_W-1:0] period,
  output logic [THRESH_W-1:0] threshold,
  output share_arr_t          shares
);

  logic [2:0]       reg_idx;
  logic [DEV_W-1:0] share_idx;
  logic             wr_en;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign share_idx = DEV_W'(reg_idx - REG_SHARE0);
  assign wr_en     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_W'(30000);
      threshold <= THRESH_W'(1000000);
      for (int i = 0; i < DEVICES; i++) begin
        shares[i] <= SHARE_W'(25);
      end
    end else if (wr_en) begin
      if (reg_idx == REG_PERIOD) begin
        period <= pwdata[PERIOD_W-1:0];
      end else if (reg_idx == REG_THRESHOLD) begin
        threshold <= pwdata[THRESH_W-1:0];
      end else if (reg_idx inside {[REG_SHARE0:REG_SHARE3]}) begin
        shares[share_idx] <= pwdata[SHARE_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_PERIOD:    prdata = APB_W'(period);
      REG_THRESHOLD: prdata = APB_W'(threshold);
      REG_SHARE0, REG_SHARE1, REG_SHARE2, REG_SHARE3: begin
        prdata = APB_W'(shares[share_idx]);
      end
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- design/csch_ctrl.sv -----
// ----------------------------------------------------------------------------
// csch_ctrl
// Sequencer of the scheduler: steps the datapath through one word at a time
// ----------------------------------------------------------------------------
module csch_ctrl import csch_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_REQUEST: begin
            cmd.do_request = 1'b1;
            state_next     = ST_DONE;
          end
          KIND_RELEASE: begin
            cmd.do_move = 1'b1;
            state_next  = ST_SCAN;
          end
          KIND_REPLENISH: begin
            cmd.do_mul = 1'b1;
            state_next = ST_RECIP_LO;
          end
          KIND_CHARGE: begin
            cmd.do_charge = 1'b1;
            state_next    = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      // one order slot per cycle until a device with waiters or the tail
      ST_SCAN: begin
        cmd.do_scan = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RECIP_LO: begin
        cmd.recip_lo = 1'b1;
        state_next   = ST_RECIP_HI;
      end
      ST_RECIP_HI: begin
        cmd.recip_hi = 1'b1;
        state_next   = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.quot   = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.do_replenish = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/csch_dp.sv -----
// ----------------------------------------------------------------------------
// csch_dp
// Datapath of the scheduler: order list, credits, waiting counts, owner,
// replenish arithmetic and the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csch_dp import csch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  input  ctrl_cmd_t            cmd,
  output ctrl_stat_t           stat,
  input  logic [PERIOD_W-1:0]  period,
  input  logic [THRESH_W-1:0]  threshold,
  input  share_arr_t           shares,
  output logic                 m_tvalid,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]  m_tuser,
  input  logic                 m_tready
);

  localparam logic [RECIP_W-1:0]           RECIP_C = RECIP_W'(RECIP);
  localparam logic signed [CREDIT_W-1:0]   INT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
  localparam logic signed [CREDIT_W-1:0]   INT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

  // captured word
  kind_t                kind;
  logic [DEV_W-1:0]     dev;
  logic [AMOUNT_W-1:0]  amount;

  // scheduler state
  logic [DEV_W-1:0]            order   [DEVICES];
  logic signed [CREDIT_W-1:0]  credit  [DEVICES];
  logic [WAIT_W-1:0]           waiting [DEVICES];
  logic                        owner_valid;
  logic [DEV_W-1:0]            owner_dev;
  logic [DEV_W-1:0]            scan_idx;

  // replenish pipeline
  logic [PROD_W-1:0]        prod;
  logic [LO_W+RECIP_W-1:0]  p_lo;
  logic [HI_W+RECIP_W-1:0]  p_hi;
  logic [QUOT_W-1:0]        q0;
  logic [QUOT_W-1:0]        add_q;

  // result and output register
  status_t              res_status;
  logic [DEV_W-1:0]     res_chosen;
  logic                 out_valid;
  status_t              out_status;
  logic [DEV_W-1:0]     out_chosen;
  logic [CREDIT_W-1:0]  out_credit;

  // combinational helpers
  logic signed [CREDIT_W-1:0]  credit_cur;
  logic [DEV_W-1:0]            move_pos;
  logic [DEV_W-1:0]            order_moved [DEVICES];
  logic [DEV_W-1:0]            scan_dev;
  logic                        scan_hit;
  logic                        scan_last;
  logic [Y_W-1:0]              y;
  logic [SUM_W-1:0]            recip_sum;
  logic [Y_W:0]                q0_x25;
  logic [Y_W:0]                rem;
  logic                        q_fix;
  logic signed [CREDIT_W:0]    repl_sum;
  logic signed [CREDIT_W-1:0]  repl_sat;
  logic signed [CREDIT_W:0]    repl_ext;
  logic signed [CREDIT_W:0]    th_pos;
  logic signed [CREDIT_W:0]    th_neg;
  logic signed [CREDIT_W-1:0]  repl_val;
  logic signed [CREDIT_W:0]    chg_diff;
  logic signed [CREDIT_W-1:0]  chg_val;
  logic [DEVICES-1:0]          order_mask;

  assign credit_cur = credit[dev];

  // move an exhausted device to the tail of the order
  always_comb begin
    move_pos = '0;
    for (int i = 0; i < DEVICES; i++) begin
      if (order[i] == dev) begin
        move_pos = DEV_W'(i);
      end
    end
    for (int i = 0; i < DEVICES - 1; i++) begin
      order_moved[i] = (DEV_W'(i) >= move_pos) ? order[i+1] : order[i];
    end
    order_moved[DEVICES-1] = dev;
  end

  // scan slot
  assign scan_dev  = order[scan_idx];
  assign scan_hit  = (waiting[scan_dev] != '0);
  assign scan_last = (scan_idx == DEV_W'(DEVICES - 1));

  // divide by 100: drop two bits, multiply by 2^27/25, fix by one step
  assign y         = prod[PROD_W-1:PCT_SHIFT];
  assign recip_sum = {p_hi, {LO_W{1'b0}}} + SUM_W'(p_lo);
  assign q0_x25    = (Y_W+1)'(q0 * PCT_ODD);
  assign rem       = {1'b0, y} - q0_x25;
  assign q_fix     = (rem >= (Y_W+1)'(PCT_ODD));

  // replenish: saturating add, then zero outside the threshold band
  always_comb begin
    repl_sum = {credit_cur[CREDIT_W-1], credit_cur}
             + {{(CREDIT_W+1-QUOT_W){1'b0}}, add_q};
    repl_sat = (!repl_sum[CREDIT_W] && repl_sum[CREDIT_W-1]) ? INT_MAX
             : repl_sum[CREDIT_W-1:0];
    repl_ext = {repl_sat[CREDIT_W-1], repl_sat};
    th_pos   = {{(CREDIT_W+1-THRESH_W){1'b0}}, threshold};
    th_neg   = -th_pos;
    repl_val = (repl_ext > th_pos || repl_ext < th_neg) ? '0 : repl_sat;
  end

  // charge: saturating subtract
  always_comb begin
    chg_diff = {credit_cur[CREDIT_W-1], credit_cur}
             - {{(CREDIT_W+1-AMOUNT_W){1'b0}}, amount};
    chg_val  = (chg_diff[CREDIT_W] && !chg_diff[CREDIT_W-1]) ? INT_MIN
             : chg_diff[CREDIT_W-1:0];
  end

  // scheduler state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEVICES; i++) begin
        order[i]   <= DEV_W'(i);
        credit[i]  <= '0;
        waiting[i] <= '0;
      end
      owner_valid <= 1'b0;
      owner_dev   <= '0;
      scan_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.do_request) begin
        if (!owner_valid || owner_dev == dev) begin
          owner_valid <= 1'b1;
          owner_dev   <= dev;
        end else if (waiting[dev] != WAIT_W'(MAX_WAITING)) begin
          waiting[dev] <= waiting[dev] + 1'b1;
        end
      end
      if (cmd.do_move) begin
        scan_idx <= '0;
        if (credit_cur <= 0) begin
          order <= order_moved;
        end
      end
      if (cmd.do_scan) begin
        if (scan_hit) begin
          waiting[scan_dev] <= waiting[scan_dev] - 1'b1;
          owner_valid       <= 1'b1;
          owner_dev         <= scan_dev;
        end else if (scan_last) begin
          owner_valid <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.do_replenish) begin
        credit[dev] <= repl_val;
      end
      if (cmd.do_charge) begin
        credit[dev] <= chg_val;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= kind_t'(s_tuser);
      dev    <= s_tdata[DEV_W-1:0];
      amount <= s_tdata[DEV_W+AMOUNT_W-1:DEV_W];
    end
    if (cmd.do_request) begin
      res_chosen <= dev;
      res_status <= (!owner_valid || owner_dev == dev) ? STAT_GRANTED : STAT_QUEUED;
    end
    if (cmd.do_move) begin
      res_chosen <= dev;
    end
    if (cmd.do_scan) begin
      if (scan_hit) begin
        res_status <= STAT_NEXT;
        res_chosen <= scan_dev;
      end else if (scan_last) begin
        res_status <= STAT_IDLE;
      end
    end
    if (cmd.do_mul || cmd.do_charge) begin
      res_status <= STAT_UPDATED;
      res_chosen <= dev;
    end
    if (cmd.do_mul) begin
      prod <= PROD_W'(period) * PROD_W'(shares[dev]);
    end
    if (cmd.recip_lo) begin
      p_lo <= (LO_W+RECIP_W)'(y[LO_W-1:0]) * (LO_W+RECIP_W)'(RECIP_C);
    end
    if (cmd.recip_hi) begin
      p_hi <= (HI_W+RECIP_W)'(y[Y_W-1:LO_W]) * (HI_W+RECIP_W)'(RECIP_C);
    end
    if (cmd.quot) begin
      q0 <= recip_sum[SUM_W-1:RECIP_SHIFT];
    end
    if (cmd.fix) begin
      add_q <= q0 + QUOT_W'(q_fix);
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_chosen <= res_chosen;
      out_credit <= credit_cur;
    end
  end

  // status to controller
  assign stat.kind      = kind;
  assign stat.scan_hit  = scan_hit;
  assign stat.scan_last = scan_last;
  assign stat.out_free  = !out_valid || m_tready;

  // output word
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(M_TDATA_W-CREDIT_W-DEV_W){1'b0}}, out_credit, out_chosen};

  // order list holds every device exactly once
  always_comb begin
    order_mask = '0;
    for (int i = 0; i < DEVICES; i++) begin
      order_mask[order[i]] = 1'b1;
    end
  end

  `ASSERT_CLK(a_order_perm, &order_mask, "service order lost a device")
  `ASSERT_CLK(a_no_overwrite, cmd.out_load |-> (!out_valid || m_tready), "result overwritten")
  `ASSERT_CLK(a_request_owned, cmd.do_request |=> owner_valid, "engine idle after request")
  `ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "output valid after reset")

endmodule

// ----- design/credit_device_scheduler.sv -----
// ----------------------------------------------------------------------------
// credit_device_scheduler
// Credit-based sharing of one engine among virtual devices
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   tuser kind, tdata device, amount
//   m_*       out        m_tvalid / m_tready   tuser status, tdata device, credit
//   p*        in         psel & penable        period, threshold, four shares
//
// One word is worked at a time. Request and charge pass through dispatch and
// done; release also scans the order list one slot per cycle, and replenish
// steps through multiply, two-part reciprocal multiply for the divide by 100,
// correction and saturating add. The next word is taken while a result waits
// in the output register; a stalled m_tready holds the sequencer only once a
// second result is ready. Reset is synchronous.
// ----------------------------------------------------------------------------
module credit_device_scheduler import csch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [APB_W-1:0]     pwdata,
  output logic [APB_W-1:0]     prdata,
  output logic                 pready,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // device[1:0], amount[25:2]
  input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
  // result words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // chosen_device[1:0], credit_now[33:2]
  output logic [STATUS_W-1:0]  m_tuser    // status[2:0]
);

  logic [PERIOD_W-1:0] period;
  logic [THRESH_W-1:0] threshold;
  share_arr_t          shares;
  ctrl_cmd_t           cmd;
  ctrl_stat_t          stat;

  // register file
  csch_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .period    (period),
    .threshold (threshold),
    .shares    (shares)
  );

  // sequencer
  csch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  csch_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .period    (period),
    .threshold (threshold),
    .shares    (shares),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tready  (m_tready)
  );

endmodule
